// File: sv/mbba_pkg.sv
// mbba_pkg: shared types and constants of the masked bitmap blitter.
// Queue entry and register file layouts; no dependencies.

package mbba_pkg;

    localparam int COLOR_W     = 16;
    localparam int COLOR_BITS  = 16;
    localparam int SUM_W       = 32;
    localparam int COUNT_W     = 21;
    localparam int SIZE_W      = 13;
    localparam int SIZE_REG_W  = 11;
    localparam int COORD_W     = 16;
    localparam int MASK_W      = 8;
    localparam int GROUP_LSB_W = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;
    localparam int DIV_STEPS   = 32;
    localparam int DIV_CNT_W   = 5;

    localparam logic [2:0] REG_BITMAP_WIDTH  = 3'd0;
    localparam logic [2:0] REG_BITMAP_HEIGHT = 3'd1;
    localparam logic [2:0] REG_ORIGIN_X      = 3'd2;
    localparam logic [2:0] REG_ORIGIN_Y      = 3'd3;
    localparam logic [2:0] REG_USE_MASK      = 3'd4;

    localparam logic KIND_DRAW    = 1'b0;
    localparam logic KIND_AVERAGE = 1'b1;

    typedef struct packed {
        logic [SIZE_REG_W-1:0]    bitmap_width;
        logic [SIZE_REG_W-1:0]    bitmap_height;
        logic signed [COORD_W-1:0] origin_x;
        logic signed [COORD_W-1:0] origin_y;
        logic                     use_mask;
    } cfg_t;

    typedef struct packed {
        logic                      has_draw;
        logic signed [COORD_W-1:0] screen_x;
        logic signed [COORD_W-1:0] screen_y;
        logic [COLOR_W-1:0]        color;
        logic                      frame_end;
        logic [SUM_W-1:0]          color_sum;
        logic [COUNT_W-1:0]        shown_count;
    } entry_t;

endpackage

// File: sv/mbba_front.sv
// mbba_front: pixel intake, raster counters, mask shifter and running sum.
// Emits one queue entry per pixel that is shown or ends the frame; uses mbba_pkg.

module mbba_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  mbba_pkg::cfg_t                  cfg,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [mbba_pkg::COLOR_W-1:0]    pixel_color,
    input  logic [mbba_pkg::MASK_W-1:0]     mask_byte,
    input  logic                            q_full,
    output logic                            q_push,
    output mbba_pkg::entry_t                q_entry
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int SW = mbba_pkg::SIZE_W;

    logic [CW-1:0]                     col_reg, col_next;
    logic [RW-1:0]                     row_reg, row_next;
    logic [mbba_pkg::MASK_W-1:0]       mask_reg, mask_next;
    logic [mbba_pkg::SUM_W-1:0]        sum_reg, sum_next;
    logic [mbba_pkg::COUNT_W-1:0]      cnt_reg, cnt_next;

    logic [SW-1:0]                     w_raw, h_raw, w_eff, h_eff;
    logic [SW-1:0]                     col_inc, row_inc;
    logic [mbba_pkg::MASK_W-1:0]       mask_cur;
    logic [mbba_pkg::SUM_W-1:0]        sum_upd;
    logic [mbba_pkg::COUNT_W-1:0]      cnt_upd;
    logic                              fire, shown, col_last, frame_end;

    assign s_tready = !q_full;
    assign fire     = s_tvalid && s_tready;

    always_comb begin
        w_raw = SW'(cfg.bitmap_width);
        h_raw = SW'(cfg.bitmap_height);
        if (w_raw == '0) begin
            w_eff = SW'(1);
        end else if (w_raw > SW'(MAX_WIDTH)) begin
            w_eff = SW'(MAX_WIDTH);
        end else begin
            w_eff = w_raw;
        end
        if (h_raw == '0) begin
            h_eff = SW'(1);
        end else if (h_raw > SW'(MAX_HEIGHT)) begin
            h_eff = SW'(MAX_HEIGHT);
        end else begin
            h_eff = h_raw;
        end

        col_inc = SW'(col_reg) + SW'(1);
        row_inc = SW'(row_reg) + SW'(1);

        if (col_reg[mbba_pkg::GROUP_LSB_W-1:0] == '0) begin
            mask_cur = mask_byte;
        end else begin
            mask_cur = {mask_reg[mbba_pkg::MASK_W-2:0], 1'b0};
        end
        shown     = !cfg.use_mask || mask_cur[mbba_pkg::MASK_W-1];
        col_last  = col_inc >= w_eff;
        frame_end = col_last && (row_inc >= h_eff);

        sum_upd = sum_reg + (shown ? mbba_pkg::SUM_W'(pixel_color) : '0);
        cnt_upd = cnt_reg + mbba_pkg::COUNT_W'(shown);

        col_next  = col_reg;
        row_next  = row_reg;
        mask_next = mask_reg;
        sum_next  = sum_reg;
        cnt_next  = cnt_reg;
        if (fire) begin
            col_next  = col_last ? '0 : CW'(col_inc);
            if (col_last) begin
                row_next = frame_end ? '0 : RW'(row_inc);
            end
            mask_next = frame_end ? '0 : mask_cur;
            sum_next  = frame_end ? '0 : sum_upd;
            cnt_next  = frame_end ? '0 : cnt_upd;
        end

        q_push                = fire && (shown || frame_end);
        q_entry.has_draw      = shown;
        q_entry.screen_x      = cfg.origin_x + mbba_pkg::COORD_W'(col_reg);
        q_entry.screen_y      = cfg.origin_y + mbba_pkg::COORD_W'(row_reg);
        q_entry.color         = pixel_color;
        q_entry.frame_end     = frame_end;
        q_entry.color_sum     = sum_upd;
        q_entry.shown_count   = cnt_upd;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            mask_reg <= '0;
            sum_reg  <= '0;
            cnt_reg  <= '0;
        end else begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            mask_reg <= mask_next;
            sum_reg  <= sum_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

// File: sv/mbba_queue.sv
// mbba_queue: short FIFO of entries between the front and back parts.
// Uses mbba_pkg for the entry type and depth.

module mbba_queue (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          push,
    input  mbba_pkg::entry_t              push_entry,
    output logic                          full,
    input  logic                          pop,
    output logic                          head_valid,
    output mbba_pkg::entry_t              head_entry,
    output logic [mbba_pkg::QUEUE_AW:0]   fill
);

    mbba_pkg::entry_t                  mem [mbba_pkg::QUEUE_DEPTH];
    logic [mbba_pkg::QUEUE_AW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [mbba_pkg::QUEUE_AW:0]       fill_reg, fill_next;
    logic                              do_push, do_pop;

    assign full       = fill_reg == (mbba_pkg::QUEUE_AW+1)'(mbba_pkg::QUEUE_DEPTH);
    assign head_valid = fill_reg != '0;
    assign head_entry = mem[rd_ptr_reg];
    assign fill       = fill_reg;
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        fill_next = fill_reg;
        if (do_push && !do_pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            fill_reg <= fill_next;
        end
    end

endmodule

// File: sv/mbba_back.sv
// mbba_back: drains queue entries into the result register; runs the
// restoring divider for the frame average. Uses mbba_pkg.

module mbba_back (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               q_valid,
    input  mbba_pkg::entry_t                   q_entry,
    output logic                               q_pop,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic                               m_kind,
    output logic signed [mbba_pkg::COORD_W-1:0] m_screen_x,
    output logic signed [mbba_pkg::COORD_W-1:0] m_screen_y,
    output logic [mbba_pkg::COLOR_W-1:0]       m_color,
    output logic                               m_empty,
    output logic                               m_last
);

    typedef enum logic [1:0] {
        ST_RUN,
        ST_DIV,
        ST_AVG
    } state_t;

    state_t                                 state_reg, state_next;
    logic                                   valid_reg, valid_next;
    logic                                   kind_reg, kind_next;
    logic signed [mbba_pkg::COORD_W-1:0]    x_reg, x_next;
    logic signed [mbba_pkg::COORD_W-1:0]    y_reg, y_next;
    logic [mbba_pkg::COLOR_W-1:0]           color_reg, color_next;
    logic                                   empty_reg, empty_next;
    logic                                   last_reg, last_next;
    logic [mbba_pkg::COUNT_W-1:0]           rem_reg, rem_next;
    logic [mbba_pkg::COUNT_W-1:0]           den_reg, den_next;
    logic [mbba_pkg::SUM_W-1:0]             quo_reg, quo_next;
    logic [mbba_pkg::DIV_CNT_W-1:0]         step_reg, step_next;
    logic                                   zero_reg, zero_next;
    logic [mbba_pkg::COUNT_W:0]             rem_sh;
    logic [mbba_pkg::COUNT_W+1:0]           diff;
    logic                                   out_free;

    assign m_tvalid   = valid_reg;
    assign m_kind     = kind_reg;
    assign m_screen_x = x_reg;
    assign m_screen_y = y_reg;
    assign m_color    = color_reg;
    assign m_empty    = empty_reg;
    assign m_last     = last_reg;

    always_comb begin
        state_next = state_reg;
        valid_next = valid_reg && !m_tready;
        kind_next  = kind_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        color_next = color_reg;
        empty_next = empty_reg;
        last_next  = last_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        quo_next   = quo_reg;
        step_next  = step_reg;
        zero_next  = zero_reg;
        q_pop      = 1'b0;
        out_free   = !valid_reg || m_tready;

        rem_sh = {rem_reg, quo_reg[mbba_pkg::SUM_W-1]};
        diff   = {1'b0, rem_sh} - {2'b00, den_reg};

        case (state_reg)
            ST_RUN: begin
                if (q_valid && out_free) begin
                    q_pop = 1'b1;
                    if (q_entry.has_draw) begin
                        valid_next = 1'b1;
                        kind_next  = mbba_pkg::KIND_DRAW;
                        x_next     = q_entry.screen_x;
                        y_next     = q_entry.screen_y;
                        color_next = q_entry.color;
                        empty_next = 1'b0;
                        last_next  = 1'b0;
                    end
                    if (q_entry.frame_end) begin
                        den_next   = q_entry.shown_count;
                        quo_next   = q_entry.color_sum;
                        rem_next   = '0;
                        step_next  = '0;
                        zero_next  = q_entry.shown_count == '0;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (!diff[mbba_pkg::COUNT_W+1]) begin
                    rem_next = diff[mbba_pkg::COUNT_W-1:0];
                end else begin
                    rem_next = rem_sh[mbba_pkg::COUNT_W-1:0];
                end
                quo_next  = {quo_reg[mbba_pkg::SUM_W-2:0], !diff[mbba_pkg::COUNT_W+1]};
                step_next = step_reg + 1'b1;
                if (step_reg == mbba_pkg::DIV_CNT_W'(mbba_pkg::DIV_STEPS - 1)) begin
                    state_next = ST_AVG;
                end
            end
            ST_AVG: begin
                if (out_free) begin
                    valid_next = 1'b1;
                    kind_next  = mbba_pkg::KIND_AVERAGE;
                    x_next     = '0;
                    y_next     = '0;
                    color_next = zero_reg ? '0 : quo_reg[mbba_pkg::COLOR_BITS-1:0];
                    empty_next = zero_reg;
                    last_next  = 1'b1;
                    state_next = ST_RUN;
                end
            end
            default: begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_RUN;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
        kind_reg  <= kind_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        color_reg <= color_next;
        empty_reg <= empty_next;
        last_reg  <= last_next;
        rem_reg   <= rem_next;
        den_reg   <= den_next;
        quo_reg   <= quo_next;
        step_reg  <= step_next;
        zero_reg  <= zero_next;
    end

endmodule

// File: sv/masked_bitmap_blit_average_core.sv
// Masked 1bpp-mask bitmap blitter with frame average colour. A pixel is
// accepted every cycle while the four-entry queue between intake and output
// has room; each shown pixel leaves as one draw request, one per cycle while
// m_tready is high and no average is in progress. At the end of a frame the
// average goes through a restoring divider that produces one quotient bit per
// cycle in 32 divider steps, and the result is then loaded into the output
// register; meanwhile the queue takes up to four further queued requests
// before s_tready drops. Registers sit on an APB port and take effect at once.
// Depends on mbba_pkg, mbba_front, mbba_queue and mbba_back.

module masked_bitmap_blit_average_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // pixel_color[15:0], mask_byte[23:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // screen_x, screen_y, color_out, empty_res[48], zeros
    output logic [0:0]  m_tuser,   // kind
    output logic        m_tlast
);

    mbba_pkg::cfg_t                           cfg_reg, cfg_next;
    logic                                     wr_en;
    logic [2:0]                               reg_idx;
    logic                                     q_push, q_full, q_pop, q_valid;
    mbba_pkg::entry_t                         push_entry, head_entry;
    logic [mbba_pkg::QUEUE_AW:0]              q_fill;
    logic                                     out_kind, out_empty;
    logic signed [mbba_pkg::COORD_W-1:0]      out_x, out_y;
    logic [mbba_pkg::COLOR_W-1:0]             out_color;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb begin
        cfg_next = cfg_reg;
        prdata   = '0;
        case (reg_idx)
            mbba_pkg::REG_BITMAP_WIDTH: begin
                prdata = 32'(cfg_reg.bitmap_width);
                if (wr_en) begin
                    cfg_next.bitmap_width = pwdata[mbba_pkg::SIZE_REG_W-1:0];
                end
            end
            mbba_pkg::REG_BITMAP_HEIGHT: begin
                prdata = 32'(cfg_reg.bitmap_height);
                if (wr_en) begin
                    cfg_next.bitmap_height = pwdata[mbba_pkg::SIZE_REG_W-1:0];
                end
            end
            mbba_pkg::REG_ORIGIN_X: begin
                prdata = 32'(unsigned'(cfg_reg.origin_x));
                if (wr_en) begin
                    cfg_next.origin_x = pwdata[mbba_pkg::COORD_W-1:0];
                end
            end
            mbba_pkg::REG_ORIGIN_Y: begin
                prdata = 32'(unsigned'(cfg_reg.origin_y));
                if (wr_en) begin
                    cfg_next.origin_y = pwdata[mbba_pkg::COORD_W-1:0];
                end
            end
            mbba_pkg::REG_USE_MASK: begin
                prdata = 32'(cfg_reg.use_mask);
                if (wr_en) begin
                    cfg_next.use_mask = pwdata[0];
                end
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.bitmap_width  <= mbba_pkg::SIZE_REG_W'(1);
            cfg_reg.bitmap_height <= mbba_pkg::SIZE_REG_W'(1);
            cfg_reg.origin_x      <= '0;
            cfg_reg.origin_y      <= '0;
            cfg_reg.use_mask      <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    mbba_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .pixel_color (s_tdata[15:0]),
        .mask_byte   (s_tdata[23:16]),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_entry     (push_entry)
    );

    mbba_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_entry (head_entry),
        .fill       (q_fill)
    );

    mbba_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (q_valid),
        .q_entry    (head_entry),
        .q_pop      (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_kind     (out_kind),
        .m_screen_x (out_x),
        .m_screen_y (out_y),
        .m_color    (out_color),
        .m_empty    (out_empty),
        .m_last     (m_tlast)
    );

    assign m_tdata = {7'b0, out_empty, out_color, out_y, out_x};
    assign m_tuser = out_kind;

    a_last_is_average: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == m_tuser[0]))
        else $error("last flag and result kind disagree");

    a_empty_colour_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[48]) |-> (m_tdata[47:32] == '0 && m_tuser[0]))
        else $error("empty average carries a colour");

    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_fill <= (mbba_pkg::QUEUE_AW+1)'(mbba_pkg::QUEUE_DEPTH))
        else $error("queue fill beyond depth");

    a_stall_only_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (q_fill == (mbba_pkg::QUEUE_AW+1)'(mbba_pkg::QUEUE_DEPTH)))
        else $error("intake stalled with queue room");

endmodule
